// ===== hdl/integer_text_formatter_macros.svh =====
// ============================================================================
// integer_text_formatter_macros
// Assertion macros shared by the formatter's checker.
// ============================================================================
`ifndef INTEGER_TEXT_FORMATTER_MACROS_SVH
`define INTEGER_TEXT_FORMATTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itf: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ITF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itf: next-cycle check failed");

`endif

// ===== hdl/itf_pkg.sv =====
// ============================================================================
// itf_pkg
// Shared constants, types and helpers of the integer text formatter.
// ============================================================================
package itf_pkg;

    localparam int VALUE_W         = 64;
    localparam int LEN_W           = 8;
    localparam int MAX_FIELD_DEF   = 48;
    localparam int DIGIT_SLOTS_DEF = 24;
    localparam int MAX_RESULTS     = 51;

    // conversion codes
    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_OCT  = 3'd2;
    localparam logic [2:0] MODE_LHEX = 3'd3;
    localparam logic [2:0] MODE_UHEX = 3'd4;
    localparam logic [2:0] MODE_PTR  = 3'd5;

    // argument size codes
    localparam logic [1:0] SIZE_INT   = 2'd0;
    localparam logic [1:0] SIZE_CHAR  = 2'd1;
    localparam logic [1:0] SIZE_SHORT = 2'd2;
    localparam logic [1:0] SIZE_LONG  = 2'd3;

    // flag bit positions
    localparam int BIT_LEFT       = 0;
    localparam int BIT_SIGN_PLUS  = 1;
    localparam int BIT_SIGN_SPACE = 2;
    localparam int BIT_ZERO_PAD   = 3;
    localparam int BIT_ALT_FORM   = 4;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    // command to the digit unit
    typedef struct packed {
        logic load;
        logic decimal;
        logic hex;
    } dcmd_t;

    // status from the digit unit
    typedef struct packed {
        logic       done;
        logic [3:0] rd_digit;
    } dstat_t;

    // Map a digit value to its ASCII code, lower or upper case letters.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {4'b0000, d};
        else if (upper)
            c = CH_UA + {4'b0000, d} - 8'd10;
        else
            c = CH_LA + {4'b0000, d} - 8'd10;
        return c;
    endfunction

endpackage

// ===== hdl/itf_digit_unit.sv =====
// ============================================================================
// itf_digit_unit
// Digit store: shift-and-add-3 binary to BCD, or octal/hex slicing.
// ============================================================================
module itf_digit_unit #(
    parameter int DIGIT_SLOTS = itf_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  itf_pkg::dcmd_t               cmd,
    input  logic [itf_pkg::VALUE_W-1:0]  value,
    input  logic [$clog2(DIGIT_SLOTS)-1:0] rd_idx,
    output itf_pkg::dstat_t              stat
);
    import itf_pkg::*;

    localparam int STEP_W = $clog2(VALUE_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_W - 1);

    logic [3:0]         digit_reg  [DIGIT_SLOTS];
    logic [3:0]         digit_next [DIGIT_SLOTS];
    logic [3:0]         adj        [DIGIT_SLOTS];
    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    always_comb
    begin
        for (int i = 0; i < DIGIT_SLOTS; i++)
        begin
            adj[i] = (digit_reg[i] >= 4'd5) ? digit_reg[i] + 4'd3 : digit_reg[i];
        end

        shift_next = shift_reg;
        step_next  = step_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        for (int i = 0; i < DIGIT_SLOTS; i++)
        begin
            digit_next[i] = digit_reg[i];
        end

        if (cmd.load)
        begin
            shift_next = value;
            step_next  = '0;
            run_next   = cmd.decimal;
            done_next  = !cmd.decimal;
            for (int i = 0; i < DIGIT_SLOTS; i++)
            begin
                if (cmd.decimal)
                    digit_next[i] = 4'd0;
                else if (cmd.hex)
                    digit_next[i] = 4'(value >> (4 * i));
                else
                    digit_next[i] = {1'b0, 3'(value >> (3 * i))};
            end
        end
        else if (run_reg)
        begin
            // adjust every BCD digit, then shift one value bit in
            digit_next[0] = {adj[0][2:0], shift_reg[VALUE_W-1]};
            for (int i = 1; i < DIGIT_SLOTS; i++)
            begin
                digit_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            step_next  = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        for (int i = 0; i < DIGIT_SLOTS; i++)
        begin
            digit_reg[i] <= digit_next[i];
        end
    end

    assign stat.done     = done_reg;
    assign stat.rd_digit = digit_reg[rd_idx];

endmodule

// ===== hdl/integer_text_formatter.sv =====
// ============================================================================
// integer_text_formatter
// Renders one integer conversion request as ASCII text, one char per strobe.
// ============================================================================
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------------------------
//  request   start && !busy         mode value arg_size flags field_width precision
//  result    strobe (one cycle)     char_code last no_text
//
//  Decimal requests run the 64-step BCD loop of the digit unit, one value
//  bit per cycle; octal/hex/pointer digits are sliced on load. The
//  leading-zero scan then walks down at most DIGIT_SLOTS slots, and the
//  text (capped at 51 chars) leaves one char per strobe, with S_SEEK between
//  segments. busy stays high from acceptance until the last char is issued.
//  Reset is asynchronous, active low, and returns the sequencer to idle.
//  The receiver cannot stall: every strobe is a completed transaction.
//
module integer_text_formatter #(
    parameter int MAX_FIELD   = itf_pkg::MAX_FIELD_DEF,
    parameter int DIGIT_SLOTS = itf_pkg::DIGIT_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [63:0] value,
    input  logic [1:0]  arg_size,
    input  logic [4:0]  flags,
    input  logic [5:0]  field_width,
    input  logic signed [6:0] precision,
    output logic        strobe,
    output logic [7:0]  char_code,
    output logic        last,
    output logic        no_text
);
    import itf_pkg::*;

    localparam int IDX_W = $clog2(DIGIT_SLOTS);
    localparam logic [LEN_W-1:0] MAX_FIELD_L = LEN_W'(MAX_FIELD);
    localparam logic [LEN_W-1:0] SCAN_TOP    = LEN_W'(DIGIT_SLOTS - 1);
    localparam logic [LEN_W-1:0] LAST_SLOT   = LEN_W'(MAX_RESULTS - 1);

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CONV  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PREP  = 7'b0001000,
        S_SEEK  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_EMPTY = 7'b1000000
    } state_t;

    // text segments in output order
    typedef enum logic [2:0] {
        SEG_LPAD  = 3'd0,
        SEG_SIGN  = 3'd1,
        SEG_PRE   = 3'd2,
        SEG_ZPAD  = 3'd3,
        SEG_ZERO  = 3'd4,
        SEG_DIGIT = 3'd5,
        SEG_RPAD  = 3'd6
    } seg_t;

    state_t           state_reg, state_next;
    seg_t             seg_reg, seg_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] out_cnt_reg, out_cnt_next;

    // per-request context
    logic [LEN_W-1:0] nd_reg, nd_next;
    logic [LEN_W-1:0] zeros_reg, zeros_next;
    logic [LEN_W-1:0] pad_reg, pad_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic [LEN_W-1:0] prec_reg, prec_next;
    logic [LEN_W-1:0] width_reg, width_next;
    logic             prec_none_reg, prec_none_next;
    logic [7:0]       sign_char_reg, sign_char_next;
    logic             sign_on_reg, sign_on_next;
    logic             pre_on_reg, pre_on_next;
    logic             upper_reg, upper_next;
    logic             nz_reg, nz_next;
    logic             left_reg, left_next;
    logic             zpad_reg, zpad_next;
    logic             oct_alt_reg, oct_alt_next;

    // output register
    logic             strobe_reg, strobe_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic             no_text_reg, no_text_next;

    // request decode
    logic [VALUE_W-1:0] mask, xm, mag;
    logic               msb, neg, valid_mode, accept;

    // prep arithmetic
    logic [LEN_W-1:0] zeros_c, body_c, pad_c, seg_len;
    logic             last_now;

    dcmd_t  dcmd;
    dstat_t dstat;

    itf_digit_unit #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_digits (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (dcmd),
        .value  (mag),
        .rd_idx (cnt_reg[IDX_W-1:0]),
        .stat   (dstat)
    );

    assign accept = start && state_reg == S_IDLE;

    // Cut the argument to its size; take the magnitude of a negative signed value.
    always_comb
    begin
        case (arg_size)
            SIZE_INT:   mask = {32'd0, {32{1'b1}}};
            SIZE_CHAR:  mask = {56'd0, {8{1'b1}}};
            SIZE_SHORT: mask = {48'd0, {16{1'b1}}};
            SIZE_LONG:  mask = {64{1'b1}};
            default:    mask = {64{1'b1}};
        endcase
        if (mode == MODE_PTR)
            mask = {64{1'b1}};
        xm = value & mask;
        case (arg_size)
            SIZE_INT:   msb = xm[31];
            SIZE_CHAR:  msb = xm[7];
            SIZE_SHORT: msb = xm[15];
            default:    msb = xm[63];
        endcase
        neg        = (mode == MODE_SDEC) && msb;
        mag        = neg ? ((~xm + 64'd1) & mask) : xm;
        valid_mode = mode inside {[MODE_SDEC:MODE_PTR]};
    end

    assign dcmd.load    = accept && valid_mode;
    assign dcmd.decimal = (mode == MODE_SDEC) || (mode == MODE_UDEC);
    assign dcmd.hex     = (mode == MODE_LHEX) || (mode == MODE_UHEX) || (mode == MODE_PTR);

    // Precision zeros, padding and total length from the digit count.
    always_comb
    begin
        zeros_c = (!prec_none_reg && prec_reg > nd_reg) ? prec_reg - nd_reg : '0;
        // octal alternate: force a leading zero only when none is there yet
        if (oct_alt_reg && zeros_c == '0 && (nd_reg == '0 || nz_reg))
            zeros_c = LEN_W'(1);
        body_c = nd_reg + zeros_c + (pre_on_reg ? LEN_W'(2) : '0)
               + {{(LEN_W-1){1'b0}}, sign_on_reg};
        pad_c  = (width_reg > body_c) ? width_reg - body_c : '0;
    end

    // Length of the segment under the cursor.
    always_comb
    begin
        case (seg_reg)
            SEG_LPAD:  seg_len = (!left_reg && !zpad_reg) ? pad_reg : '0;
            SEG_SIGN:  seg_len = {{(LEN_W-1){1'b0}}, sign_on_reg};
            SEG_PRE:   seg_len = pre_on_reg ? LEN_W'(2) : '0;
            SEG_ZPAD:  seg_len = zpad_reg ? pad_reg : '0;
            SEG_ZERO:  seg_len = zeros_reg;
            SEG_DIGIT: seg_len = nd_reg;
            SEG_RPAD:  seg_len = left_reg ? pad_reg : '0;
            default:   seg_len = '0;
        endcase
    end

    assign last_now = (out_cnt_reg == total_reg - 1'b1) || (out_cnt_reg == LAST_SLOT);

    // Sequencer: accept, convert, scan, size the fields, then issue chars or a no-text marker.
    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        cnt_next       = cnt_reg;
        out_cnt_next   = out_cnt_reg;
        nd_next        = nd_reg;
        zeros_next     = zeros_reg;
        pad_next       = pad_reg;
        total_next     = total_reg;
        prec_next      = prec_reg;
        width_next     = width_reg;
        prec_none_next = prec_none_reg;
        sign_char_next = sign_char_reg;
        sign_on_next   = sign_on_reg;
        pre_on_next    = pre_on_reg;
        upper_next     = upper_reg;
        nz_next        = nz_reg;
        left_next      = left_reg;
        zpad_next      = zpad_reg;
        oct_alt_next   = oct_alt_reg;
        strobe_next    = 1'b0;
        char_next      = char_reg;
        last_next      = last_reg;
        no_text_next   = no_text_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // capture the request context, saturate width and precision
                    prec_none_next = precision[6];
                    prec_next      = ({2'b00, precision[5:0]} > MAX_FIELD_L)
                                   ? MAX_FIELD_L : {2'b00, precision[5:0]};
                    width_next     = ({2'b00, field_width} > MAX_FIELD_L)
                                   ? MAX_FIELD_L : {2'b00, field_width};
                    nz_next        = |mag;
                    upper_next     = (mode == MODE_UHEX);
                    left_next      = flags[BIT_LEFT];
                    zpad_next      = flags[BIT_ZERO_PAD] && !flags[BIT_LEFT] && precision[6];
                    oct_alt_next   = (mode == MODE_OCT) && flags[BIT_ALT_FORM];
                    pre_on_next    = (mode == MODE_PTR)
                                   || (((mode == MODE_LHEX) || (mode == MODE_UHEX))
                                       && flags[BIT_ALT_FORM] && (|mag));
                    sign_char_next = CH_NUL;
                    if (mode == MODE_SDEC)
                    begin
                        if (neg)
                            sign_char_next = CH_MINUS;
                        else if (flags[BIT_SIGN_PLUS])
                            sign_char_next = CH_PLUS;
                        else if (flags[BIT_SIGN_SPACE])
                            sign_char_next = CH_SPACE;
                    end
                    sign_on_next = (mode == MODE_SDEC)
                                 && (neg || flags[BIT_SIGN_PLUS] || flags[BIT_SIGN_SPACE]);
                    state_next   = valid_mode ? S_CONV : S_EMPTY;
                end
            end

            S_CONV:
            begin
                if (dstat.done)
                begin
                    cnt_next   = SCAN_TOP;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // walk down from the top slot to the first nonzero digit
                if (dstat.rd_digit != 4'd0 || cnt_reg == '0)
                begin
                    if (dstat.rd_digit == 4'd0 && !prec_none_reg && prec_reg == '0)
                        nd_next = '0;
                    else
                        nd_next = cnt_reg + 1'b1;
                    state_next = S_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            S_PREP:
            begin
                zeros_next   = zeros_c;
                pad_next     = pad_c;
                total_next   = body_c + pad_c;
                out_cnt_next = '0;
                seg_next     = SEG_LPAD;
                state_next   = (body_c + pad_c == '0) ? S_EMPTY : S_SEEK;
            end

            S_SEEK:
            begin
                // skip empty segments, load the count of the next one
                if (seg_len == '0)
                begin
                    seg_next = seg_t'(seg_reg + 3'd1);
                end
                else
                begin
                    cnt_next   = seg_len - 1'b1;
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                strobe_next  = 1'b1;
                last_next    = last_now;
                no_text_next = 1'b0;
                case (seg_reg)
                    SEG_LPAD:  char_next = CH_SPACE;
                    SEG_SIGN:  char_next = sign_char_reg;
                    SEG_PRE:   char_next = (cnt_reg != '0) ? CH_ZERO
                                         : (upper_reg ? CH_UX : CH_LX);
                    SEG_ZPAD:  char_next = CH_ZERO;
                    SEG_ZERO:  char_next = CH_ZERO;
                    SEG_DIGIT: char_next = digit_char(dstat.rd_digit, upper_reg);
                    SEG_RPAD:  char_next = CH_SPACE;
                    default:   char_next = CH_NUL;
                endcase
                out_cnt_next = out_cnt_reg + 1'b1;
                if (last_now)
                begin
                    state_next = S_IDLE;
                end
                else if (cnt_reg == '0)
                begin
                    seg_next   = seg_t'(seg_reg + 3'd1);
                    state_next = S_SEEK;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            S_EMPTY:
            begin
                // no text: one marker transaction
                strobe_next  = 1'b1;
                char_next    = CH_NUL;
                last_next    = 1'b1;
                no_text_next = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            seg_reg     <= SEG_LPAD;
            cnt_reg     <= '0;
            out_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seg_reg     <= seg_next;
            cnt_reg     <= cnt_next;
            out_cnt_reg <= out_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        nd_reg        <= nd_next;
        zeros_reg     <= zeros_next;
        pad_reg       <= pad_next;
        total_reg     <= total_next;
        prec_reg      <= prec_next;
        width_reg     <= width_next;
        prec_none_reg <= prec_none_next;
        sign_char_reg <= sign_char_next;
        sign_on_reg   <= sign_on_next;
        pre_on_reg    <= pre_on_next;
        upper_reg     <= upper_next;
        nz_reg        <= nz_next;
        left_reg      <= left_next;
        zpad_reg      <= zpad_next;
        oct_alt_reg   <= oct_alt_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
        no_text_reg   <= no_text_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;
    assign no_text   = no_text_reg;

endmodule

// ===== hdl/itf_checker.sv =====
// ============================================================================
// itf_checker
// Port-level checks of the formatter's request and result transactions.
// ============================================================================
`include "integer_text_formatter_macros.svh"

module itf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input logic last,
    input logic no_text
);

    // an empty rendering is a single, final transaction
    `ITF_ASSERT_NOW(a_empty_is_last, strobe && no_text, last)

    // an accepted request holds busy and shows no char in the next cycle
    `ITF_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe)

    // a char that is not the last keeps the block busy
    `ITF_ASSERT_NOW(a_mid_text_busy, strobe && !last, busy)

    // drop the strobe after the final char of a request
    `ITF_ASSERT_NEXT(a_gap_after_last, strobe && last, !strobe)

endmodule

bind integer_text_formatter itf_checker u_itf_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .strobe  (strobe),
    .last    (last),
    .no_text (no_text)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for integer_text_formatter: drives conversion
// requests, renders each one in a local printf-style model and checks every
// emitted character, with random gaps between requests.
// ============================================================================
module tb;

    import itf_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 5;
    localparam int MAX_FIELD_TB = 48;
    localparam int DIGIT_SLOTS_TB = 24;
    localparam int MAX_CHARS = 51;
    localparam int RANDOM_REQUESTS = 105;
    // Longest honest silence is a decimal conversion plus its gap.
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;

    localparam logic [6:0] PREC_NONE = 7'h7F;

    // conversion codes with no meaning: they render nothing
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    // One character of a rendering as the block reports it.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       none;
    } text_char_t;

    // ------------------------------------------------------------------------
    // Rendering model and expected character store
    // ------------------------------------------------------------------------
    class render_board;

        text_char_t expected_chars[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        // Render one accepted request and queue the characters it must emit.
        function void note_request(logic [2:0] md, logic [63:0] val, logic [1:0] sz,
                                   logic [4:0] fl, logic [5:0] fw, logic [6:0] pr);
            int          wid;
            int          prc;
            int          bits;
            int          base;
            int          zeros;
            int          body;
            int          pad;
            int          count;
            logic [63:0] mask;
            logic [63:0] x;
            logic [63:0] m;
            logic [3:0]  d;
            logic [7:0]  sign_ch;
            logic [7:0]  pfx_ch;
            int          pfx_len;
            bit          upper;
            bit          left;
            bit          zpad;
            logic [7:0]  digs[$];
            logic [7:0]  text[$];
            text_char_t  tc;

            wid = (int'(fw) > MAX_FIELD_TB) ? MAX_FIELD_TB : int'(fw);
            if (pr[6])
                prc = -1;
            else
                prc = (int'(pr) > MAX_FIELD_TB) ? MAX_FIELD_TB : int'(pr);
            left = fl[BIT_LEFT];

            // Unused conversions render nothing at all.
            if (md <= MODE_PTR)
            begin
                case (sz)
                    SIZE_INT:   bits = 32;
                    SIZE_CHAR:  bits = 8;
                    SIZE_SHORT: bits = 16;
                    default:    bits = 64;
                endcase
                if (md == MODE_PTR)
                    bits = 64;
                mask = (bits == 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
                x = val & mask;

                // Pick the sign: negative value first, then plus, then space.
                sign_ch = CH_NUL;
                if (md == MODE_SDEC)
                begin
                    if (x[bits - 1])
                    begin
                        sign_ch = CH_MINUS;
                        x = (~x + 64'd1) & mask;
                    end
                    else if (fl[BIT_SIGN_PLUS])
                        sign_ch = CH_PLUS;
                    else if (fl[BIT_SIGN_SPACE])
                        sign_ch = CH_SPACE;
                end

                base = (md <= MODE_UDEC) ? 10 : (md == MODE_OCT) ? 8 : 16;
                upper = (md == MODE_UHEX);

                // Alternate hex prefix only for nonzero; pointer always 0x.
                pfx_len = 0;
                pfx_ch = CH_LX;
                if ((md == MODE_LHEX || md == MODE_UHEX) && fl[BIT_ALT_FORM] && x != 64'd0)
                begin
                    pfx_len = 2;
                    pfx_ch = upper ? CH_UX : CH_LX;
                end
                if (md == MODE_PTR)
                    pfx_len = 2;

                // Collect digits, least significant first; zero precision
                // with a zero value yields none.
                if (!(prc == 0 && x == 64'd0))
                begin
                    m = x;
                    do
                    begin
                        d = 4'(m % 64'(base));
                        if (d < 4'd10)
                            digs.push_back(CH_ZERO + {4'd0, d});
                        else
                            digs.push_back((upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10);
                        m = m / 64'(base);
                    end
                    while (m != 64'd0 && digs.size() < DIGIT_SLOTS_TB);
                end

                zeros = (prc > digs.size()) ? prc - digs.size() : 0;
                // Octal alternate: make sure the first digit is a zero.
                if (md == MODE_OCT && fl[BIT_ALT_FORM] && zeros == 0 &&
                    (digs.size() == 0 || x != 64'd0))
                    zeros = 1;

                body = digs.size() + zeros + pfx_len + ((sign_ch != CH_NUL) ? 1 : 0);
                pad = (wid > body) ? wid - body : 0;
                zpad = fl[BIT_ZERO_PAD] && !left && prc < 0;

                if (!left && !zpad)
                    repeat (pad) text.push_back(CH_SPACE);
                if (sign_ch != CH_NUL)
                    text.push_back(sign_ch);
                if (pfx_len == 2)
                begin
                    text.push_back(CH_ZERO);
                    text.push_back(pfx_ch);
                end
                if (zpad)
                    repeat (pad) text.push_back(CH_ZERO);
                repeat (zeros) text.push_back(CH_ZERO);
                for (int i = digs.size() - 1; i >= 0; i--)
                    text.push_back(digs[i]);
                if (left)
                    repeat (pad) text.push_back(CH_SPACE);
            end

            if (text.size() == 0)
            begin
                tc.code = CH_NUL;
                tc.last = 1'b1;
                tc.none = 1'b1;
                expected_chars.push_back(tc);
            end
            else
            begin
                count = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
                for (int i = 0; i < count; i++)
                begin
                    tc.code = text[i];
                    tc.last = (i == count - 1);
                    tc.none = 1'b0;
                    expected_chars.push_back(tc);
                end
            end
        endfunction

        // Compare one emitted character against the oldest expectation.
        function void check_char(logic [7:0] code, logic last, logic none);
            text_char_t exp_c;
            if (expected_chars.size() == 0)
            begin
                $error("char 0x%0h (last %0b no_text %0b) with nothing expected",
                       code, last, none);
                mismatches++;
                return;
            end
            exp_c = expected_chars.pop_front();
            if (code !== exp_c.code)
            begin
                $error("char_code expected 0x%0h got 0x%0h", exp_c.code, code);
                mismatches++;
            end
            if (last !== exp_c.last)
            begin
                $error("last expected %0b got %0b", exp_c.last, last);
                mismatches++;
            end
            if (none !== exp_c.none)
            begin
                $error("no_text expected %0b got %0b", exp_c.none, none);
                mismatches++;
            end
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Block hookup
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  mode;
    logic [63:0] value;
    logic [1:0]  arg_size;
    logic [4:0]  flags;
    logic [5:0]  field_width;
    logic signed [6:0] precision;
    logic        strobe;
    logic [7:0]  char_code;
    logic        last;
    logic        no_text;

    render_board board = new();

    integer_text_formatter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .value       (value),
        .arg_size    (arg_size),
        .flags       (flags),
        .field_width (field_width),
        .precision   (precision),
        .strobe      (strobe),
        .char_code   (char_code),
        .last        (last),
        .no_text     (no_text)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    // Idle a random number of cycles, then hold start with the payload until
    // a transaction completes (start high, busy low at the edge). start stays
    // high on return so a back-to-back request never toggles it within a step.
    task automatic send_request(logic [2:0] md, logic [63:0] val, logic [1:0] sz,
                                logic [4:0] fl, logic [5:0] fw, logic [6:0] pr);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        mode        <= md;
        value       <= val;
        arg_size    <= sz;
        flags       <= fl;
        field_width <= fw;
        precision   <= pr;
        do
            @(posedge clk);
        while (busy);
        board.note_request(md, val, sz, fl, fw, pr);
    endtask

    // Draw one request, biased toward short widths and absent precision.
    task automatic send_random_request();
        logic [2:0]  md;
        logic [63:0] val;
        logic [1:0]  sz;
        logic [4:0]  fl;
        logic [5:0]  fw;
        logic [6:0]  pr;
        int          r;

        r = $urandom_range(0, 99);
        md = (r < 6) ? 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_B))
                     : 3'($urandom_range(MODE_SDEC, MODE_PTR));

        case ($urandom_range(0, 4))
            0: val = 64'($urandom_range(0, 20));
            1: val = {$urandom, $urandom};
            2: val = {32'hFFFF_FFFF, $urandom};
            3:
            begin
                case ($urandom_range(0, 4))
                    0: val = 64'd0;
                    1: val = {64{1'b1}};
                    2: val = 64'h8000_0000_0000_0000;
                    3: val = 64'h7FFF_FFFF_FFFF_FFFF;
                    default: val = 64'h0000_0000_8000_0000;
                endcase
            end
            default: val = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase

        sz = 2'($urandom_range(0, 3));
        fl = 5'($urandom_range(0, 31));

        r = $urandom_range(0, 99);
        if (r < 50)
            fw = 6'($urandom_range(0, 12));
        else if (r < 85)
            fw = 6'($urandom_range(13, 48));
        else
            fw = 6'($urandom_range(49, 63));

        r = $urandom_range(0, 99);
        if (r < 45)
            pr = PREC_NONE;
        else if (r < 55)
            pr = 7'($urandom_range(64, 126));
        else if (r < 70)
            pr = 7'd0;
        else if (r < 90)
            pr = 7'($urandom_range(1, 24));
        else
            pr = 7'($urandom_range(25, 63));

        send_request(md, val, sz, fl, fw, pr);
    endtask

    // ------------------------------------------------------------------------
    // Result monitor: every strobe is a completed transaction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_char(char_code, last, no_text);
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no transaction on either side
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_SDEC;
        value       = 64'd0;
        arg_size    = SIZE_INT;
        flags       = 5'd0;
        field_width = 6'd0;
        precision   = PREC_NONE;

        // Hold reset, then release it on an edge.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: sign rules, size cuts, prefixes, precision and pad.
        // Plain zero, then the most negative int and long.
        send_request(MODE_SDEC, 64'd0, SIZE_INT, 5'b00000, 6'd0, PREC_NONE);
        send_request(MODE_SDEC, 64'h0000_0000_8000_0000, SIZE_INT, 5'b00000, 6'd0, PREC_NONE);
        send_request(MODE_SDEC, 64'h8000_0000_0000_0000, SIZE_LONG, 5'b00000, 6'd0, PREC_NONE);
        // Negative char beats plus; plus beats space.
        send_request(MODE_SDEC, 64'h0000_0000_0000_00FF, SIZE_CHAR, 5'b00010, 6'd0, PREC_NONE);
        send_request(MODE_SDEC, 64'hFFFF_FFFF_FFFF_7FFF, SIZE_SHORT, 5'b00110, 6'd0, PREC_NONE);
        // Space sign with zero padding after it.
        send_request(MODE_SDEC, 64'd5, SIZE_INT, 5'b01100, 6'd6, PREC_NONE);
        // Largest unsigned long.
        send_request(MODE_UDEC, {64{1'b1}}, SIZE_LONG, 5'b00000, 6'd0, PREC_NONE);
        // Zero with zero precision: no characters at all.
        send_request(MODE_UDEC, 64'd0, SIZE_INT, 5'b00000, 6'd0, 7'd0);
        // Octal alternate: zero with zero precision still shows one zero.
        send_request(MODE_OCT, 64'd0, SIZE_INT, 5'b10000, 6'd0, 7'd0);
        send_request(MODE_OCT, 64'd8, SIZE_INT, 5'b10000, 6'd0, 7'd3);
        send_request(MODE_OCT, {64{1'b1}}, SIZE_LONG, 5'b10001, 6'd48, PREC_NONE);
        // Hex prefix, zeros padded behind it.
        send_request(MODE_LHEX, 64'h0000_0000_DEAD_BEEF, SIZE_INT, 5'b11000, 6'd20, PREC_NONE);
        // Alternate hex of zero gets no prefix.
        send_request(MODE_UHEX, 64'd0, SIZE_LONG, 5'b10000, 6'd4, PREC_NONE);
        send_request(MODE_UHEX, 64'h0000_0000_0000_0ABC, SIZE_LONG, 5'b10000, 6'd0, 7'd48);
        // Pointer ignores size, plus, space and alternate.
        send_request(MODE_PTR, 64'd0, SIZE_CHAR, 5'b10110, 6'd0, PREC_NONE);
        send_request(MODE_PTR, {64{1'b1}}, SIZE_CHAR, 5'b01000, 6'd63, PREC_NONE);
        // Unused conversions render nothing.
        send_request(MODE_SPARE_A, 64'd123, SIZE_INT, 5'b00000, 6'd10, PREC_NONE);
        send_request(MODE_SPARE_B, {64{1'b1}}, SIZE_LONG, 5'b11111, 6'd63, 7'd63);
        // Left alignment with precision zeros.
        send_request(MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFD6, SIZE_INT, 5'b00001, 6'd10, 7'd5);
        // Oversized precision saturates.
        send_request(MODE_SDEC, 64'd1, SIZE_INT, 5'b00010, 6'd0, 7'd63);
        // Negative precision acts as none, so zero padding applies.
        send_request(MODE_UDEC, 64'd77, SIZE_SHORT, 5'b01000, 6'd8, 7'h40);
        // A precision turns zero padding into spaces.
        send_request(MODE_UDEC, 64'd77, SIZE_SHORT, 5'b01000, 6'd8, 7'd3);
        send_request(MODE_SDEC, 64'h8000_0000_0000_0001, SIZE_LONG, 5'b00000, 6'd48, 7'd48);
        send_request(MODE_LHEX, 64'h0000_0000_0000_0001, SIZE_LONG, 5'b00000, 6'd63, PREC_NONE);
        // Char size drops the upper bits.
        send_request(MODE_UDEC, 64'h0000_0000_0000_01FF, SIZE_CHAR, 5'b00000, 6'd0, PREC_NONE);

        // Random part.
        repeat (RANDOM_REQUESTS) send_random_request();

        // Drop start, drain the expected characters, then watch for strays.
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/itf_pkg.sv
hdl/itf_digit_unit.sv
hdl/integer_text_formatter.sv
hdl/itf_checker.sv
test/tb.sv
